@@ src/sem_pkg.sv @@
// Package for the siren envelope and modulation block: widths, register indexes,
// reset values, fixed-point constants and the 2^x table with its helper functions.
// Depends on nothing; imported by siren_envelope_modulation.
`timescale 1ns / 1ps

package sem_pkg;

    // Port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // Exponent table geometry
    localparam int EXP_TABLE_BITS = 8;
    localparam int EXP_FRAC_BITS  = 24;
    localparam int EXP_N          = 1 << EXP_TABLE_BITS;
    localparam int FRAC_SH        = EXP_FRAC_BITS - EXP_TABLE_BITS;

    // Fixed-point limits
    localparam logic [31:0] MULT_ONE         = 32'd268435456;
    localparam logic [31:0] MULT_MIN         = 32'd33554432;
    localparam logic [31:0] MULT_MAX         = 32'h8000_0000;
    localparam logic [24:0] ENV_ONE          = 25'd16777216;
    localparam logic [18:0] FREQ_MIN         = 19'd320;
    localparam logic [18:0] FREQ_MAX         = 19'd320000;
    localparam logic [15:0] SEVEN_TENTHS_Q16 = 16'd45875;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OSC_BASE     = 3'd0,
        REG_CUTOFF_BASE  = 3'd1,
        REG_MOD_DEPTH    = 3'd2,
        REG_ATTACK_STEP  = 3'd3,
        REG_RELEASE_STEP = 3'd4,
        REG_RISE_COEF    = 3'd5,
        REG_FALL_COEF    = 3'd6,
        REG_SWEEP_MODE   = 3'd7
    } t_reg_idx;

    // Sweep direction codes; the unused code behaves as off
    localparam logic [1:0] SWEEP_FALL = 2'd0;
    localparam logic [1:0] SWEEP_OFF  = 2'd1;
    localparam logic [1:0] SWEEP_RISE = 2'd2;

    // Register reset values
    localparam logic [16:0] RST_OSC_BASE     = 17'd7040;
    localparam logic [18:0] RST_CUTOFF_BASE  = 19'd128000;
    localparam logic [16:0] RST_MOD_DEPTH    = 17'd22938;
    localparam logic [24:0] RST_ATTACK_STEP  = 25'd69905;
    localparam logic [24:0] RST_RELEASE_STEP = 25'd6991;
    localparam logic [31:0] RST_RISE_COEF    = 32'd1074672543;
    localparam logic [30:0] RST_FALL_COEF    = 31'd1072811964;
    localparam logic [1:0]  RST_SWEEP_MODE   = SWEEP_OFF;

    typedef logic [31:0] t_pow_tab [0:EXP_N];

    // Table read result: base entry, slope, interpolation fraction and shift code.
    // The shift code is the final right shift minus 39.
    typedef struct packed {
        logic [31:0]        t0;
        logic [31:0]        d;
        logic [FRAC_SH-1:0] fr;
        logic [1:0]         sh;
    } t_lookup;

    // Integer square root, used only while the table is built at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bv;
        x   = x_in;
        res = '0;
        bv  = 64'd1 << 62;
        while (bv > x) begin
            bv = bv >> 2;
        end
        while (bv != 64'd0) begin
            if (x >= res + bv) begin
                x   = x - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    // Q30 table of 2^(i/EXP_N) from repeated square roots of two.
    function automatic t_pow_tab build_pow_tab();
        logic [63:0] roots [0:EXP_TABLE_BITS];
        logic [63:0] v;
        t_pow_tab    tab;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= EXP_TABLE_BITS; j++) begin
            roots[j] = isqrt64(roots[j-1] << 30);
        end
        for (int i = 0; i < EXP_N; i++) begin
            v = 64'd1 << 30;
            for (int j = 0; j < EXP_TABLE_BITS; j++) begin
                if (((i >> j) & 1) != 0) begin
                    v = (v * roots[EXP_TABLE_BITS-j] + (64'd1 << 29)) >> 30;
                end
            end
            tab[i] = v[31:0];
        end
        tab[EXP_N] = 32'h8000_0000;
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = build_pow_tab();

    // Split a signed Q24 octave magnitude into table entry, slope and shift.
    function automatic t_lookup pow_lookup(input logic [24:0] mag, input logic neg);
        logic [EXP_FRAC_BITS-1:0]  f;
        logic [EXP_TABLE_BITS-1:0] idx;
        logic [EXP_TABLE_BITS:0]   idx1;
        logic [31:0]               t1;
        t_lookup                   lk;
        // A negative exponent borrows one octave and takes the complement fraction
        f    = neg ? (~mag[EXP_FRAC_BITS-1:0] + 24'd1) : mag[EXP_FRAC_BITS-1:0];
        idx  = f[EXP_FRAC_BITS-1 -: EXP_TABLE_BITS];
        idx1 = {1'b0, idx} + 1'b1;
        lk.fr = f[FRAC_SH-1:0];
        lk.t0 = POW_TAB[idx];
        t1    = POW_TAB[idx1];
        lk.d  = (t1 > lk.t0) ? (t1 - lk.t0) : 32'd0;
        if (!neg) begin
            lk.sh = mag[24] ? 2'd0 : 2'd1;
        end else if (mag[EXP_FRAC_BITS-1:0] != '0) begin
            lk.sh = mag[24] ? 2'd3 : 2'd2;
        end else begin
            lk.sh = mag[24] ? 2'd2 : 2'd1;
        end
        return lk;
    endfunction

    // Rounded right shift by 39 plus the shift code, then clamp to the audio range.
    function automatic logic [18:0] freq_scale(input logic [63:0] q, input logic [1:0] sh);
        logic [64:0] sum;
        logic [25:0] res;
        logic [18:0] out;
        sum = {1'b0, q} + (65'd1 << (38 + sh));
        res = 26'(sum >> (39 + sh));
        if (res < 26'(FREQ_MIN)) begin
            out = FREQ_MIN;
        end else if (res > 26'(FREQ_MAX)) begin
            out = FREQ_MAX;
        end else begin
            out = res[18:0];
        end
        return out;
    endfunction

endpackage

@@ src/siren_envelope_modulation.sv @@
// Top level of the siren envelope and modulation block: tick sequencer, shared
// multiplier, sweep and envelope state, configuration registers and output register.
// Depends on sem_pkg for constants, the 2^x table and its helper functions.
`timescale 1ns / 1ps

// Each request carries the gate and one LFO sample and produces one result with the
// oscillator frequency, the filter cutoff, the envelope level and the LFO reset pulse.
// A request runs through the sweep, depth, oscillator and filter lookup, interpolation,
// power and scaling steps and the envelope step, which loads the output register; only
// then is the next request taken, so the block holds one request at a time. The steps
// follow a single 32 x 32 multiplier that computes nine products per tick in sequence
// (sweep step, depth, two base scalings, filter depth, two interpolations, two final
// scalings). A waiting result holds the sequencer in its last step only if the output
// register is still full when the next result is ready.
module siren_envelope_modulation
    import sem_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [0] gate, [16:1] lfo_sample, [23:17] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [18:0] osc_freq, [37:19] cutoff frequency, [62:38] env_gain, [63] lfo_reset
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DEPTH,
        ST_OBASE,
        ST_OLOOK,
        ST_OINTERP,
        ST_OPOW,
        ST_OSCALE,
        ST_FINTERP,
        ST_FPOW,
        ST_FSCALE,
        ST_ENV
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [16:0] r_osc_base;
    logic [18:0] r_cutoff_base;
    logic [16:0] r_mod_depth;
    logic [24:0] r_attack_step;
    logic [24:0] r_release_step;
    logic [31:0] r_rise_coef;
    logic [30:0] r_fall_coef;
    logic [1:0]  r_sweep_mode;

    // Tick state
    logic        r_gate_before;
    logic        r_sweep_on;
    logic [31:0] r_mult;
    logic [24:0] r_env;

    // Per-request working registers
    logic        r_gate;
    logic        r_neg;
    logic [15:0] r_lmag;
    logic        r_lreset;
    logic [63:0] r_prod;
    logic [31:0] r_dprod;
    logic [24:0] r_mag;
    logic [31:0] r_p;
    logic [31:0] r_t0;
    logic [31:0] r_d;
    logic [FRAC_SH-1:0] r_fr;
    logic [1:0]  r_sh_o;
    logic [1:0]  r_sh_f;
    logic [31:0] r_pw;
    logic [18:0] r_freq_o;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Shared multiplier operands
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_en;
    logic [63:0] mul_p;

    // Write-back values
    logic [63:0] sw_sum;
    logic [33:0] sw_m;
    logic [31:0] n_mult;
    logic [32:0] osc_sum;
    logic [47:0] flt_sum;
    logic [50:0] p_sum;
    logic [48:0] ip_sum;
    logic [31:0] ip_add;
    logic [31:0] n_pw;
    t_lookup     lk;
    logic [18:0] freq_f;
    logic [25:0] env_up;
    logic [24:0] n_env;
    logic        out_load;
    logic        accept;
    logic        sweep_active;
    logic [15:0] in_lfo;
    logic        in_gate;

    assign in_gate = i_s_axis_tdata[0];
    assign in_lfo  = i_s_axis_tdata[16:1];
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;

    assign sweep_active = r_sweep_on
                       && (r_sweep_mode == SWEEP_FALL || r_sweep_mode == SWEEP_RISE);

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        unique case (r_state) inside
            ST_SWEEP: begin
                mul_a  = r_mult;
                mul_b  = (r_sweep_mode == SWEEP_RISE) ? r_rise_coef : 32'(r_fall_coef);
                mul_en = 1'b1;
            end
            ST_DEPTH: begin
                mul_a  = 32'(r_lmag);
                mul_b  = 32'(r_mod_depth);
                mul_en = 1'b1;
            end
            ST_OBASE: begin
                mul_a  = 32'(r_osc_base);
                mul_b  = r_mult;
                mul_en = 1'b1;
            end
            ST_OLOOK: begin
                mul_a  = r_dprod;
                mul_b  = 32'(SEVEN_TENTHS_Q16);
                mul_en = 1'b1;
            end
            ST_OINTERP, ST_FINTERP: begin
                mul_a  = r_d;
                mul_b  = 32'(r_fr);
                mul_en = 1'b1;
            end
            ST_OPOW: begin
                mul_a  = 32'(r_cutoff_base);
                mul_b  = r_mult;
                mul_en = 1'b1;
            end
            ST_OSCALE, ST_FSCALE: begin
                mul_a  = r_p;
                mul_b  = r_pw;
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Sweep step: round to Q4.28 and clamp to one eighth .. eight
    assign sw_sum = r_prod + 64'd536870912;
    assign sw_m   = sw_sum[63:30];
    always_comb begin
        if (sw_m < 34'(MULT_MIN)) begin
            n_mult = MULT_MIN;
        end else if (sw_m > 34'(MULT_MAX)) begin
            n_mult = MULT_MAX;
        end else begin
            n_mult = sw_m[31:0];
        end
    end

    // Exponent magnitudes in Q24 octaves for the oscillator and the filter
    assign osc_sum = {1'b0, r_prod[31:0]} + 33'd64;
    assign flt_sum = r_prod[47:0] + 48'd4194304;

    // Base times multiplier, rounded to nearest in Q10
    assign p_sum = r_prod[50:0] + 51'd131072;

    // Linear interpolation between neighbouring table entries
    assign ip_sum = {1'b0, r_prod[47:0]} + 49'(64'd1 << (FRAC_SH - 1));
    assign ip_add = 32'(ip_sum >> FRAC_SH);
    assign n_pw   = r_t0 + ip_add;

    // Table read for whichever channel is in r_mag
    assign lk = pow_lookup(r_mag, r_neg);

    // Filter result comes straight from the last product
    assign freq_f = freq_scale(r_prod, r_sh_f);

    // Linear envelope step, clamped to zero .. unity
    assign env_up = {1'b0, r_env} + {1'b0, r_attack_step};
    always_comb begin
        if (r_gate) begin
            n_env = (env_up > 26'(ENV_ONE)) ? ENV_ONE : env_up[24:0];
        end else begin
            n_env = (r_release_step >= r_env) ? 25'd0 : (r_env - r_release_step);
        end
    end

    assign out_load = (r_state == ST_ENV) && (!r_out_valid || i_m_axis_tready);

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_osc_base     <= RST_OSC_BASE;
            r_cutoff_base  <= RST_CUTOFF_BASE;
            r_mod_depth    <= RST_MOD_DEPTH;
            r_attack_step  <= RST_ATTACK_STEP;
            r_release_step <= RST_RELEASE_STEP;
            r_rise_coef    <= RST_RISE_COEF;
            r_fall_coef    <= RST_FALL_COEF;
            r_sweep_mode   <= RST_SWEEP_MODE;
            r_gate_before  <= 1'b0;
            r_sweep_on     <= 1'b0;
            r_mult         <= MULT_ONE;
            r_env          <= '0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_addr))
                    REG_OSC_BASE:     r_osc_base     <= i_cfg_data[16:0];
                    REG_CUTOFF_BASE:  r_cutoff_base  <= i_cfg_data[18:0];
                    REG_MOD_DEPTH:    r_mod_depth    <= i_cfg_data[16:0];
                    REG_ATTACK_STEP:  r_attack_step  <= i_cfg_data[24:0];
                    REG_RELEASE_STEP: r_release_step <= i_cfg_data[24:0];
                    REG_RISE_COEF:    r_rise_coef    <= i_cfg_data;
                    REG_FALL_COEF:    r_fall_coef    <= i_cfg_data[30:0];
                    REG_SWEEP_MODE:   r_sweep_mode   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (mul_en) begin
                r_prod <= mul_p;
            end

            // Output register: filled by the last step, drained by the consumer
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        // Gate edges act before the sweep step
                        r_gate        <= in_gate;
                        r_neg         <= in_lfo[15];
                        r_lmag        <= in_lfo[15] ? (~in_lfo + 16'd1) : in_lfo;
                        r_lreset      <= in_gate && !r_gate_before;
                        r_gate_before <= in_gate;
                        if (in_gate && !r_gate_before) begin
                            r_mult     <= MULT_ONE;
                            r_sweep_on <= 1'b0;
                        end else if (!in_gate && r_gate_before) begin
                            r_sweep_on <= 1'b1;
                        end
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    r_state <= ST_DEPTH;
                end
                ST_DEPTH: begin
                    if (sweep_active) begin
                        r_mult <= n_mult;
                    end
                    r_state <= ST_OBASE;
                end
                ST_OBASE: begin
                    r_dprod <= r_prod[31:0];
                    r_mag   <= osc_sum[31:7];
                    r_state <= ST_OLOOK;
                end
                ST_OLOOK: begin
                    r_p     <= p_sum[49:18];
                    r_t0    <= lk.t0;
                    r_d     <= lk.d;
                    r_fr    <= lk.fr;
                    r_sh_o  <= lk.sh;
                    r_state <= ST_OINTERP;
                end
                ST_OINTERP: begin
                    r_mag   <= flt_sum[47:23];
                    r_state <= ST_OPOW;
                end
                ST_OPOW: begin
                    // Oscillator power completes while the filter table is read
                    r_pw    <= n_pw;
                    r_t0    <= lk.t0;
                    r_d     <= lk.d;
                    r_fr    <= lk.fr;
                    r_sh_f  <= lk.sh;
                    r_state <= ST_OSCALE;
                end
                ST_OSCALE: begin
                    r_p     <= p_sum[49:18];
                    r_state <= ST_FINTERP;
                end
                ST_FINTERP: begin
                    r_freq_o <= freq_scale(r_prod, r_sh_o);
                    r_state  <= ST_FPOW;
                end
                ST_FPOW: begin
                    r_pw    <= n_pw;
                    r_state <= ST_FSCALE;
                end
                ST_FSCALE: begin
                    r_state <= ST_ENV;
                end
                ST_ENV: begin
                    if (out_load) begin
                        r_env      <= n_env;
                        r_out_data <= {r_lreset, n_env, freq_f, r_freq_o};
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The sweep multiplier never leaves one eighth .. eight.
    a_mult_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mult >= MULT_MIN && r_mult <= MULT_MAX)
        else $error("sweep multiplier out of range");

    // Every result shown holds frequencies and level within their clamps.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[18:0] >= FREQ_MIN
                          && o_m_axis_tdata[18:0] <= FREQ_MAX
                          && o_m_axis_tdata[37:19] >= FREQ_MIN
                          && o_m_axis_tdata[37:19] <= FREQ_MAX
                          && o_m_axis_tdata[62:38] <= ENV_ONE))
        else $error("result field out of range");

    // Only one request is in the sequencer at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("request accepted while busy");

    // A rising gate restarts the sweep from unity with the sweep stopped.
    a_gate_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_gate && !r_gate_before) |=> (!r_sweep_on && r_mult == MULT_ONE))
        else $error("rising gate did not reset the sweep");

endmodule
